// ===== rtl/ndd_pkg.sv =====
package ndd_pkg;

	localparam int unsigned MaxNodesDefault = 32;
	localparam int unsigned DataW = 40;
	localparam int unsigned FracW = 24;
	localparam int unsigned StatusW = 3;

	localparam logic [StatusW-1:0] ST_OK = 3'd0;
	localparam logic [StatusW-1:0] ST_NOT_READY = 3'd1;
	localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [StatusW-1:0] ST_SATURATED = 3'd3;
	localparam logic [StatusW-1:0] ST_FULL = 3'd4;

	// signed 40-bit limits
	localparam logic signed [DataW-1:0] POS_MAX = {1'b0, {(DataW-1){1'b1}}};
	localparam logic signed [DataW-1:0] NEG_MIN = {1'b1, {(DataW-1){1'b0}}};

	// magnitude of a signed 41-bit value
	function automatic logic [DataW:0] mag41(input logic signed [DataW:0] v);
		mag41 = v[DataW] ? (~v + 1'b1) : v;
	endfunction

	// clamp a magnitude with sign to 40 bits; bit DataW of result flags saturation
	function automatic logic [DataW:0] clamp_mag(input logic [63:0] m, input logic neg);
		logic [63:0] lim;
		logic [DataW-1:0] r;
		logic s;
		lim = neg ? (64'd1 << (DataW-1)) : ((64'd1 << (DataW-1)) - 64'd1);
		s = (m > lim);
		r = s ? lim[DataW-1:0] : m[DataW-1:0];
		clamp_mag = {s, neg ? (~r + 1'b1) : r};
	endfunction

	// saturate a signed 41-bit value to 40 bits; bit DataW flags saturation
	function automatic logic [DataW:0] sat41(input logic signed [DataW:0] v);
		logic s;
		s = (v[DataW] != v[DataW-1]);
		sat41 = {s, s ? (v[DataW] ? NEG_MIN : POS_MAX) : v[DataW-1:0]};
	endfunction

endpackage

// ===== rtl/newton_divided_difference_interp.sv =====
// Newton interpolator. Node beats load (x, y); the beat marked last_node runs
// the divided-difference build: each of the n(n-1)/2 updates goes around the
// bit-serial divider. A query runs the Horner walk through the bit-serial
// multiplier, one multiply per stored node beyond the first. A node load
// without build passes through the load and done states. busy is high from the
// accepting edge until the result strobe; each result stands for one cycle on
// valid and the receiver cannot stall.
module newton_divided_difference_interp #(
	parameter int unsigned MAX_NODES = ndd_pkg::MaxNodesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic signed [ndd_pkg::DataW-1:0] x_value,
	input  logic signed [ndd_pkg::DataW-1:0] y_value,
	input  logic last_node,
	output logic valid,
	output logic signed [ndd_pkg::DataW-1:0] interp_value,
	output logic [ndd_pkg::StatusW-1:0] status
);
	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW = $clog2(MAX_NODES + 1);
	localparam int unsigned DW = ndd_pkg::DataW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_BRD = 4'd2;
	localparam logic [3:0] S_BRD2 = 4'd3;
	localparam logic [3:0] S_BDIV = 4'd4;
	localparam logic [3:0] S_BWAIT = 4'd5;
	localparam logic [3:0] S_QRD = 4'd6;
	localparam logic [3:0] S_QRD2 = 4'd7;
	localparam logic [3:0] S_QMUL = 4'd8;
	localparam logic [3:0] S_QWAIT = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;
	localparam logic [3:0] S_QTOP = 4'd11;
	localparam logic [3:0] S_BDEN = 4'd12;

	logic [3:0] state_q;
	logic signed [DW-1:0] xs_mem [MAX_NODES];
	logic signed [DW-1:0] cf_mem [MAX_NODES];
	logic [CW-1:0] cnt_q;
	logic ready_q;
	logic req_q, last_q, full_q, dup_q, sat_q;
	logic signed [DW-1:0] x_q, y_q, r_q;
	logic [AW-1:0] i_q, k_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] ra_q, rb_q;
	logic signed [DW-1:0] xa_q, xb_q, ca_q, cb_q;
	logic signed [DW:0] den_q;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic signed [DW-1:0] wr_x, wr_c;
	logic wr_x_en;
	logic signed [DW:0] dden, dnum, qdiff;
	logic [DW:0] nsat, hsum;
	logic div_go, div_done, div_sat, mul_go, mul_done, mul_sat;
	logic signed [DW-1:0] div_q, mul_p;
	logic [ndd_pkg::StatusW-1:0] st_d;

	// two read ports, one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cf_mem[wr_addr] <= wr_c;
			if (wr_x_en) xs_mem[wr_addr] <= wr_x;
		end
		xa_q <= xs_mem[ra_q];
		ca_q <= cf_mem[ra_q];
		xb_q <= xs_mem[rb_q];
		cb_q <= cf_mem[rb_q];
	end

	assign dden = {xa_q[DW-1], xa_q} - {xb_q[DW-1], xb_q};
	assign qdiff = {ca_q[DW-1], ca_q} - {cb_q[DW-1], cb_q};
	assign nsat = ndd_pkg::sat41(qdiff);
	assign dnum = {x_q[DW-1], x_q} - {xb_q[DW-1], xb_q};
	assign hsum = ndd_pkg::sat41({cb_q[DW-1], cb_q} + {mul_p[DW-1], mul_p});

	ndd_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(nsat[DW-1:0]), .den(den_q),
		.done(div_done), .q(div_q), .sat(div_sat)
	);

	ndd_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go),
		.a(dnum), .b({r_q[DW-1], r_q}),
		.done(mul_done), .p(mul_p), .sat(mul_sat)
	);

	assign busy = (state_q != S_IDLE);
	assign div_go = (state_q == S_BDIV) && (den_q != '0);
	assign mul_go = (state_q == S_QMUL);

	always_comb begin
		wr_en = 1'b0;
		wr_x_en = 1'b0;
		wr_addr = i_q;
		wr_x = x_q;
		wr_c = y_q;
		if (state_q == S_LOAD && !full_q) begin
			wr_en = 1'b1;
			wr_x_en = 1'b1;
			wr_addr = AW'(cnt_q);
		end else if (state_q == S_BDIV && den_q == '0) begin
			wr_en = 1'b1;
			wr_c = '0;
		end else if (state_q == S_BWAIT && div_done) begin
			wr_en = 1'b1;
			wr_c = div_q;
		end
	end

	always_comb begin
		if (dup_q) st_d = ndd_pkg::ST_DUPLICATE;
		else if (sat_q) st_d = ndd_pkg::ST_SATURATED;
		else if (full_q) st_d = ndd_pkg::ST_FULL;
		else st_d = ndd_pkg::ST_OK;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ready_q <= 1'b0;
			valid <= 1'b0;
			status <= ndd_pkg::ST_OK;
			interp_value <= '0;
			full_q <= 1'b0;
			dup_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			valid <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req_type;
						last_q <= last_node;
						x_q <= x_value;
						y_q <= y_value;
						dup_q <= 1'b0;
						sat_q <= 1'b0;
						full_q <= !req_type && !ready_q && (cnt_q >= CW'(MAX_NODES));
						if (req_type) begin
							if (!ready_q || cnt_q == '0) begin
								state_q <= S_DONE;
							end else begin
								k_q <= AW'(cnt_q - CW'(1));
								ra_q <= AW'(cnt_q - CW'(1));
								state_q <= S_QTOP;
							end
						end else begin
							if (ready_q) begin
								cnt_q <= '0;
								ready_q <= 1'b0;
							end
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					if (!full_q) cnt_q <= cnt_q + CW'(1);
					if (last_q && (cnt_q != '0 || !full_q)) begin
						j_q <= CW'(1);
						i_q <= full_q ? AW'(cnt_q - CW'(1)) : AW'(cnt_q);
						state_q <= S_BRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_BRD: begin
					// stop when j reaches node count
					if (j_q >= cnt_q) begin
						if (dup_q) begin
							cnt_q <= '0;
							ready_q <= 1'b0;
						end else begin
							ready_q <= 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						ra_q <= i_q;
						rb_q <= i_q - AW'(j_q);
						state_q <= S_BRD2;
					end
				end
				S_BRD2: begin
					// turn port b to the lower coefficient
					rb_q <= i_q - AW'(1);
					state_q <= S_BDEN;
				end
				S_BDEN: begin
					// hold the abscissa difference while port b reads the coefficient
					den_q <= dden;
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					if (nsat[DW]) sat_q <= 1'b1;
					if (den_q == '0) begin
						dup_q <= 1'b1;
						state_q <= S_BWAIT;
						i_q <= i_q;
					end else begin
						state_q <= S_BWAIT;
					end
				end
				S_BWAIT: begin
					if (div_done || dup_q && !div_done && wr_en == 1'b0) begin
						if (div_done && div_sat) sat_q <= 1'b1;
						if (CW'(i_q) == j_q) begin
							j_q <= j_q + CW'(1);
							i_q <= AW'(cnt_q - CW'(1));
						end else begin
							i_q <= i_q - AW'(1);
						end
						state_q <= S_BRD;
					end
				end
				S_QTOP: begin
					state_q <= S_QRD;
				end
				S_QRD: begin
					r_q <= ca_q;
					if (k_q == '0) begin
						interp_value <= ca_q;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q - AW'(1);
						rb_q <= k_q - AW'(1);
						state_q <= S_QRD2;
					end
				end
				S_QRD2: begin
					state_q <= S_QMUL;
				end
				S_QMUL: begin
					state_q <= S_QWAIT;
				end
				S_QWAIT: begin
					if (mul_done) begin
						if (mul_sat || hsum[DW]) sat_q <= 1'b1;
						r_q <= hsum[DW-1:0];
						if (k_q == '0) begin
							interp_value <= hsum[DW-1:0];
							state_q <= S_DONE;
						end else begin
							k_q <= k_q - AW'(1);
							rb_q <= k_q - AW'(1);
							state_q <= S_QRD2;
						end
					end
				end
				S_DONE: begin
					if (!req_q) begin
						interp_value <= '0;
						status <= st_d;
					end else if (!ready_q || cnt_q == '0) begin
						interp_value <= '0;
						status <= ndd_pkg::ST_NOT_READY;
					end else begin
						status <= sat_q ? ndd_pkg::ST_SATURATED : ndd_pkg::ST_OK;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// duplicate write path: once a zero divisor has been flagged, leave the wait
	// state without waiting for the divider; no divide is launched for a zero divisor

	assert property (@(posedge clk) disable iff (!arst_n) valid |-> !busy)
		else $error("result strobe while busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_NODES))
		else $error("node count beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == ndd_pkg::ST_NOT_READY) |-> interp_value == '0)
		else $error("refused query carries a value");
endmodule

// ===== rtl/ndd_serial_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, signed-magnitude,
// Q16.24 product rounded half away from zero and saturated to 40 bits.
module ndd_serial_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic signed [ndd_pkg::DataW:0] a,
	input  logic signed [ndd_pkg::DataW:0] b,
	output logic done,
	output logic signed [ndd_pkg::DataW-1:0] p,
	output logic sat
);
	localparam int unsigned W = ndd_pkg::DataW + 1;
	localparam int unsigned PW = 2 * W;

	logic [PW-1:0] mcand_q;
	logic [W-1:0] mplier_q;
	logic [PW-1:0] acc_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [PW-1:0] rnd;
	logic [63:0] m;
	logic [ndd_pkg::DataW:0] cl;

	// step one bit of the multiplier a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= !go && busy_q && (cnt_q == 6'(W - 1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'(W - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// shift the multiplicand up and the multiplier down, add on a set bit
	always_ff @(posedge clk) begin
		if (go) begin
			mcand_q <= {{W{1'b0}}, ndd_pkg::mag41(a)};
			mplier_q <= ndd_pkg::mag41(b);
			acc_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			acc_q <= acc_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// round and clamp the finished product
	always_comb begin
		rnd = acc_q + (PW'(1) << (ndd_pkg::FracW - 1));
		m = (rnd[PW-1:ndd_pkg::FracW] >> 63) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF
			: 64'(rnd >> ndd_pkg::FracW);
		cl = ndd_pkg::clamp_mag(m, neg_q);
	end

	assign p = cl[ndd_pkg::DataW-1:0];
	assign sat = cl[ndd_pkg::DataW];
endmodule

// ===== rtl/ndd_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, rounded half away from zero.
module ndd_serial_div (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic signed [ndd_pkg::DataW-1:0] num,
	input  logic signed [ndd_pkg::DataW:0] den,
	output logic done,
	output logic signed [ndd_pkg::DataW-1:0] q,
	output logic sat
);
	localparam int unsigned NW = ndd_pkg::DataW + ndd_pkg::FracW + 1;
	localparam int unsigned DW = ndd_pkg::DataW + 1;

	logic [NW-1:0] n_q;
	logic [NW-1:0] quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] d_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [DW:0] trial;
	logic [63:0] qr;
	logic [ndd_pkg::DataW:0] cl;
	logic [ndd_pkg::DataW:0] nm;

	assign nm = ndd_pkg::mag41({num[ndd_pkg::DataW-1], num});
	assign trial = {rem_q[DW-1:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= !go && busy_q && (cnt_q == 7'(NW - 1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 7'(NW - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// shift one numerator bit in, subtract if it fits
	always_ff @(posedge clk) begin
		if (go) begin
			// numerator scaled by 2^24
			n_q <= {nm, {ndd_pkg::FracW{1'b0}}};
			d_q <= ndd_pkg::mag41(den);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[ndd_pkg::DataW-1] ^ den[ndd_pkg::DataW];
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= trial - {1'b0, d_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// round: remainder at least half the divisor
	always_comb begin
		qr = 64'(quo_q) + (({rem_q, 1'b0} >= {1'b0, d_q}) ? 64'd1 : 64'd0);
		cl = ndd_pkg::clamp_mag(qr, neg_q);
	end

	assign q = cl[ndd_pkg::DataW-1:0];
	assign sat = cl[ndd_pkg::DataW];
endmodule
